### rtl/dwpd_pkg.sv
// shared types and constants for the dual wheel pid drive
`timescale 1ns / 1ps

package dwpd_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int INTEGRAL_BITS = 32;
    localparam int GAIN_BITS     = 24;
    localparam int LIMIT_BITS    = 15;
    localparam int POWER_BITS    = 16;
    localparam int INDEX_BITS    = 2;

    localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = 24'd25231;
    localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RESET = 24'd164;
    localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RESET = 24'd9830;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2
    } reg_index_t;

    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef struct packed {
        logic                  kind;
        logic [COUNT_BITS-1:0] left_count;
        logic [COUNT_BITS-1:0] right_count;
        logic [COUNT_BITS-1:0] target_count;
        logic [LIMIT_BITS-1:0] power_limit;
    } in_t;

    typedef struct packed {
        logic signed [POWER_BITS-1:0] left_power;
        logic signed [POWER_BITS-1:0] right_power;
        logic                         done_res;
    } out_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic load1;
        logic load2;
    } lane_ctl_t;

endpackage

### rtl/dwpd_lane.sv
// one wheel pid lane: state update, gain products, sum and clamp
`timescale 1ns / 1ps

module dwpd_lane #(
    parameter int INTEGRAL_BITS = dwpd_pkg::INTEGRAL_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dwpd_pkg::lane_ctl_t                   ctl,
    input  logic [dwpd_pkg::COUNT_BITS-1:0]       goal,
    input  logic [dwpd_pkg::COUNT_BITS-1:0]       count,
    input  logic [dwpd_pkg::GAIN_BITS-1:0]        prop_gain,
    input  logic [dwpd_pkg::GAIN_BITS-1:0]        integ_gain,
    input  logic [dwpd_pkg::GAIN_BITS-1:0]        deriv_gain,
    input  logic [dwpd_pkg::LIMIT_BITS-1:0]       limit,
    output logic signed [dwpd_pkg::POWER_BITS-1:0] power
);

    localparam int CB = dwpd_pkg::COUNT_BITS;
    localparam int GB = dwpd_pkg::GAIN_BITS;
    localparam int IB = INTEGRAL_BITS;
    localparam int AW = ((IB > CB + 1) ? IB : CB + 1) + 1;
    localparam int PW = CB + GB + 2;
    localparam int IW = IB + GB + 1;
    localparam int DW = CB + GB + 3;
    localparam int SW = ((IW > DW) ? IW : DW) + 2;

    localparam logic signed [AW-1:0] ACC_MAX = {{(AW-IB+1){1'b0}}, {(IB-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {{(AW-IB+1){1'b1}}, {(IB-1){1'b0}}};

    logic signed [IB-1:0] integ_reg;
    logic signed [CB:0]   prev_reg;
    logic signed [CB:0]   err_reg;
    logic signed [IB-1:0] acc_reg;
    logic signed [CB+1:0] der_reg;
    logic signed [PW-1:0] pp_reg;
    logic signed [IW-1:0] ip_reg;
    logic signed [DW-1:0] dp_reg;

    logic signed [CB:0]    err_next;
    logic signed [AW-1:0]  acc_wide;
    logic signed [IB-1:0]  acc_next;
    logic signed [CB+1:0]  der_next;
    logic signed [SW-1:0]  sum;
    logic signed [SW-1:0]  shifted;
    logic signed [SW-1:0]  lim_pos;
    logic signed [SW-1:0]  lim_neg;
    logic signed [SW-1:0]  clamped;

    assign err_next = $signed({1'b0, goal}) - $signed({1'b0, count});
    assign acc_wide = AW'(integ_reg) + AW'(err_next);
    assign der_next = (CB+2)'(err_next) - (CB+2)'(prev_reg);

    always_comb
    begin
        if (acc_wide > ACC_MAX)
        begin
            acc_next = ACC_MAX[IB-1:0];
        end
        else if (acc_wide < ACC_MIN)
        begin
            acc_next = ACC_MIN[IB-1:0];
        end
        else
        begin
            acc_next = acc_wide[IB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (ctl.step)
        begin
            integ_reg <= acc_next;
            prev_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load1)
        begin
            err_reg <= err_next;
            acc_reg <= acc_next;
            der_reg <= der_next;
        end
        if (ctl.load2)
        begin
            pp_reg <= $signed({1'b0, prop_gain}) * err_reg;
            ip_reg <= $signed({1'b0, integ_gain}) * acc_reg;
            dp_reg <= $signed({1'b0, deriv_gain}) * der_reg;
        end
    end

    assign sum     = SW'(pp_reg) + SW'(ip_reg) + SW'(dp_reg);
    assign shifted = sum >>> 8;
    assign lim_pos = $signed(SW'(limit));
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (shifted > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (shifted < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = shifted;
        end
    end

    assign power = clamped[dwpd_pkg::POWER_BITS-1:0];

endmodule

### rtl/dual_wheel_pid_drive.sv
// top level: request control, goal check, two pid lanes and result merge
// path: error/integral registers, then gain product registers, then the output register
// throughput: one request per cycle while in_stall is low, set by the lane state update loop
// three-stage pipeline (error/integral, gain products, sum/clamp), each stage moves when
// the next one is free; in_stall rises only when all three stages are full and out_stall is high
// reset: gains take their defaults, integrals and previous errors clear, block idles done
`timescale 1ns / 1ps

module dual_wheel_pid_drive #(
    parameter int INTEGRAL_BITS = dwpd_pkg::INTEGRAL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [dwpd_pkg::INDEX_BITS-1:0]   cfg_index,
    input  logic [dwpd_pkg::GAIN_BITS-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dwpd_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dwpd_pkg::out_t                    out_data
);

    localparam int CB = dwpd_pkg::COUNT_BITS;

    logic [dwpd_pkg::GAIN_BITS-1:0]  prop_gain_reg;
    logic [dwpd_pkg::GAIN_BITS-1:0]  integ_gain_reg;
    logic [dwpd_pkg::GAIN_BITS-1:0]  deriv_gain_reg;
    logic [CB-1:0]                   goal_reg;
    logic [dwpd_pkg::LIMIT_BITS-1:0] limit_reg;
    logic                            finished_reg;

    logic                            v1_reg;
    logic                            v2_reg;
    logic                            out_valid_reg;
    logic                            zero1_reg;
    logic                            zero2_reg;
    logic                            done1_reg;
    logic                            done2_reg;
    logic [dwpd_pkg::LIMIT_BITS-1:0] limit1_reg;
    logic [dwpd_pkg::LIMIT_BITS-1:0] limit2_reg;
    dwpd_pkg::out_t                  out_data_reg;

    logic                 ready1;
    logic                 ready2;
    logic                 ready3;
    logic                 accept;
    logic                 is_start;
    logic                 reached;
    logic                 step;
    logic                 zero_next;
    logic                 done_next;
    logic [CB:0]          count_sum;
    logic [CB:0]          goal_twice;
    dwpd_pkg::lane_ctl_t  ctl;
    logic signed [dwpd_pkg::POWER_BITS-1:0] left_power;
    logic signed [dwpd_pkg::POWER_BITS-1:0] right_power;

    assign ready3   = !out_valid_reg || !out_stall;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;
    assign accept   = in_valid && ready1;

    assign is_start   = (in_data.kind == dwpd_pkg::KIND_START);
    assign count_sum  = {1'b0, in_data.left_count} + {1'b0, in_data.right_count};
    assign goal_twice = {goal_reg, 1'b0};
    assign reached    = (count_sum >= goal_twice);
    assign step       = accept && !is_start && !finished_reg && !reached;
    assign zero_next  = is_start || finished_reg || reached;
    assign done_next  = !is_start && (finished_reg || reached);

    assign ctl.clear = accept && is_start;
    assign ctl.step  = step;
    assign ctl.load1 = accept;
    assign ctl.load2 = v1_reg && ready2;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= dwpd_pkg::PROP_GAIN_RESET;
            integ_gain_reg <= dwpd_pkg::INTEG_GAIN_RESET;
            deriv_gain_reg <= dwpd_pkg::DERIV_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dwpd_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                dwpd_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                dwpd_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg     <= '0;
            limit_reg    <= '0;
            finished_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (is_start)
            begin
                goal_reg     <= in_data.target_count;
                limit_reg    <= in_data.power_limit;
                finished_reg <= 1'b0;
            end
            else if (reached)
            begin
                finished_reg <= 1'b1;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    // sideband payload
    always_ff @(posedge clk)
    begin
        if (ctl.load1)
        begin
            zero1_reg  <= zero_next;
            done1_reg  <= done_next;
            limit1_reg <= limit_reg;
        end
        if (ctl.load2)
        begin
            zero2_reg  <= zero1_reg;
            done2_reg  <= done1_reg;
            limit2_reg <= limit1_reg;
        end
        if (v2_reg && ready3)
        begin
            out_data_reg.left_power  <= zero2_reg ? '0 : left_power;
            out_data_reg.right_power <= zero2_reg ? '0 : right_power;
            out_data_reg.done_res    <= done2_reg;
        end
    end

    dwpd_lane #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_left_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .goal       (goal_reg),
        .count      (in_data.left_count),
        .prop_gain  (prop_gain_reg),
        .integ_gain (integ_gain_reg),
        .deriv_gain (deriv_gain_reg),
        .limit      (limit2_reg),
        .power      (left_power)
    );

    dwpd_lane #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_right_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .goal       (goal_reg),
        .count      (in_data.right_count),
        .prop_gain  (prop_gain_reg),
        .integ_gain (integ_gain_reg),
        .deriv_gain (deriv_gain_reg),
        .limit      (limit2_reg),
        .power      (right_power)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/sv/dual_wheel_pid_drive_test.sv
`timescale 1ns / 1ps
// testbench for dual_wheel_pid_drive: directed and random moves checked against a pid predictor

module dual_wheel_pid_drive_test;

    localparam int COUNT_BITS    = dwpd_pkg::COUNT_BITS;
    localparam int INTEGRAL_BITS = dwpd_pkg::INTEGRAL_BITS;
    localparam int GAIN_BITS     = dwpd_pkg::GAIN_BITS;
    localparam int LIMIT_BITS    = dwpd_pkg::LIMIT_BITS;
    localparam int POWER_BITS    = dwpd_pkg::POWER_BITS;
    localparam int INDEX_BITS    = dwpd_pkg::INDEX_BITS;

    localparam logic [INDEX_BITS-1:0] REG_SPARE = 2'd3;
    localparam logic [GAIN_BITS-1:0]  GAIN_MAX  = '1;
    localparam longint PRODUCT_CAP = 64'sd1 <<< 62;
    localparam longint INTEG_MAX   = (64'sd1 <<< (INTEGRAL_BITS - 1)) - 1;
    localparam longint INTEG_MIN   = -INTEG_MAX - 1;
    localparam int     COUNT_TOP   = (1 << COUNT_BITS) - 1;
    localparam int     LIMIT_TOP   = (1 << LIMIT_BITS) - 1;

    class pid_scoreboard;
        logic [GAIN_BITS-1:0] prop_k;
        logic [GAIN_BITS-1:0] integ_k;
        logic [GAIN_BITS-1:0] deriv_k;
        longint sum_left;
        longint sum_right;
        longint last_err_left;
        longint last_err_right;
        longint goal;
        longint cap;
        bit     stopped;
        dwpd_pkg::out_t expected_q[$];
        int     failures;

        function new();
            prop_k         = dwpd_pkg::PROP_GAIN_RESET;
            integ_k        = dwpd_pkg::INTEG_GAIN_RESET;
            deriv_k        = dwpd_pkg::DERIV_GAIN_RESET;
            sum_left       = 0;
            sum_right      = 0;
            last_err_left  = 0;
            last_err_right = 0;
            goal           = 0;
            cap            = 0;
            stopped        = 1;
            failures       = 0;
        endfunction

        function void set_gain(logic [INDEX_BITS-1:0] idx, logic [GAIN_BITS-1:0] value);
            case (idx)
                dwpd_pkg::REG_PROP_GAIN:  prop_k = value;
                dwpd_pkg::REG_INTEG_GAIN: integ_k = value;
                dwpd_pkg::REG_DERIV_GAIN: deriv_k = value;
                default: ;
            endcase
        endfunction

        // gain product, magnitude capped at 2^62
        function longint scaled(logic [GAIN_BITS-1:0] gain, longint x);
            longint g;
            longint mag;
            g   = longint'(gain);
            mag = (x < 0) ? -x : x;
            if (g != 0 && mag > PRODUCT_CAP / g)
                mag = PRODUCT_CAP / g;
            return (x < 0) ? -(mag * g) : mag * g;
        endfunction

        function logic signed [POWER_BITS-1:0] lane_power(longint count, inout longint acc,
                                                         inout longint last_err);
            longint err;
            longint der;
            longint total;
            longint p;
            err = goal - count;
            der = err - last_err;
            acc = acc + err;
            if (acc > INTEG_MAX)
                acc = INTEG_MAX;
            else if (acc < INTEG_MIN)
                acc = INTEG_MIN;
            last_err = err;
            total = scaled(prop_k, err) + scaled(integ_k, acc) + scaled(deriv_k, der);
            p = total >>> 8;
            if (p > cap)
                p = cap;
            else if (p < -cap)
                p = -cap;
            return p[POWER_BITS-1:0];
        endfunction

        function void note_request(dwpd_pkg::in_t r);
            dwpd_pkg::out_t res;
            res = '0;
            if (r.kind == dwpd_pkg::KIND_START)
            begin
                goal           = longint'(r.target_count);
                cap            = longint'(r.power_limit);
                sum_left       = 0;
                sum_right      = 0;
                last_err_left  = 0;
                last_err_right = 0;
                stopped        = 0;
            end
            else if (stopped)
            begin
                res.done_res = 1'b1;
            end
            else if (longint'(r.left_count) + longint'(r.right_count) >= 2 * goal)
            begin
                stopped      = 1;
                res.done_res = 1'b1;
            end
            else
            begin
                res.left_power  = lane_power(longint'(r.left_count), sum_left, last_err_left);
                res.right_power = lane_power(longint'(r.right_count), sum_right,
                                             last_err_right);
            end
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(dwpd_pkg::out_t got);
            dwpd_pkg::out_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d %0d %0b", $time,
                         got.left_power, got.right_power, got.done_res);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("left_power", int'(want.left_power), int'(got.left_power));
            compare_field("right_power", int'(want.right_power), int'(got.right_power));
            compare_field("done_res", int'(want.done_res), int'(got.done_res));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [INDEX_BITS-1:0] cfg_index;
    logic [GAIN_BITS-1:0]  cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    dwpd_pkg::in_t         in_data;
    logic                  out_valid;
    logic                  out_stall;
    dwpd_pkg::out_t        out_data;

    pid_scoreboard book = new();
    int tx_max_wait = 16;
    int rx_max_wait = 16;
    bit hold_long = 0;

    dual_wheel_pid_drive uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            book.note_request(in_data);
        if (rst_n && out_valid && !out_stall)
            book.check_result(out_data);
    end

    // result side: random stalls, plus one long hold-off when asked
    initial
    begin
        int wait_cycles;
        out_stall <= 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_long)
            begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                hold_long = 0;
            end
            wait_cycles = $urandom_range(0, rx_max_wait);
            if (wait_cycles > 0)
            begin
                out_stall <= 1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic dwpd_pkg::in_t start_item(int target, int lim);
        dwpd_pkg::in_t r;
        r              = dwpd_pkg::in_t'({$urandom, $urandom});
        r.kind         = dwpd_pkg::KIND_START;
        r.target_count = target[COUNT_BITS-1:0];
        r.power_limit  = lim[LIMIT_BITS-1:0];
        return r;
    endfunction

    function automatic dwpd_pkg::in_t sample_item(int left, int right);
        dwpd_pkg::in_t r;
        r             = dwpd_pkg::in_t'({$urandom, $urandom});
        r.kind        = dwpd_pkg::KIND_SAMPLE;
        r.left_count  = left[COUNT_BITS-1:0];
        r.right_count = right[COUNT_BITS-1:0];
        return r;
    endfunction

    function automatic int near(int base, int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > COUNT_TOP)
            v = COUNT_TOP;
        return v;
    endfunction

    task automatic send_request(dwpd_pkg::in_t r);
        int gap;
        gap = $urandom_range(0, tx_max_wait);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (book.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_gains(logic [GAIN_BITS-1:0] p, logic [GAIN_BITS-1:0] i,
                                 logic [GAIN_BITS-1:0] d);
        logic [INDEX_BITS-1:0] idx [4];
        logic [GAIN_BITS-1:0]  vals [4];
        int k;
        idx  = '{dwpd_pkg::REG_PROP_GAIN, dwpd_pkg::REG_INTEG_GAIN, dwpd_pkg::REG_DERIV_GAIN,
                 REG_SPARE};
        vals = '{p, i, d, GAIN_BITS'($urandom)};
        for (k = 0; k < 4; k++)
        begin
            cfg_write <= 1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            book.set_gain(idx[k], vals[k]);
        end
        cfg_write <= 0;
    endtask

    // moves that ramp both wheels toward the target, with some noise requests
    task automatic run_moves(int total);
        int sent;
        int steps;
        int target;
        int lim;
        int spread;
        int k;
        sent = 0;
        while (sent < total)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(dwpd_pkg::in_t'({$urandom, $urandom}));
                sent++;
            end
            else
            begin
                target = $urandom_range(0, 1) ? $urandom_range(0, COUNT_TOP)
                                              : $urandom_range(0, 400);
                lim    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LIMIT_TOP)
                                                     : $urandom_range(0, 25600);
                spread = $urandom_range(0, 1) ? 30 : target / 8 + 8;
                steps  = $urandom_range(2, 16);
                send_request(start_item(target, lim));
                sent++;
                for (k = 1; k <= steps + 2 && sent < total; k++)
                begin
                    send_request(sample_item(near(target * k / steps, spread),
                                             near(target * k / steps, spread)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     <= 0;
        cfg_write <= 0;
        cfg_index <= dwpd_pkg::REG_PROP_GAIN;
        cfg_data  <= '0;
        in_valid  <= 0;
        in_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // sample before any start
        send_request(sample_item(100, 200));
        // zero goal and zero limit
        send_request(start_item(0, 0));
        send_request(sample_item(0, 0));
        send_request(sample_item(5, 5));
        // largest goal, limit above the nominal range
        send_request(start_item(COUNT_TOP, LIMIT_TOP));
        send_request(sample_item(0, 0));
        send_request(sample_item(COUNT_TOP, 0));
        send_request(sample_item(0, COUNT_TOP));
        send_request(sample_item(COUNT_TOP, COUNT_TOP - 1));
        send_request(sample_item(COUNT_TOP, COUNT_TOP));
        // overshoot on one wheel, goal reached exactly
        send_request(start_item(1000, 25600));
        send_request(sample_item(1200, 0));
        send_request(sample_item(0, 1200));
        send_request(sample_item(999, 1000));
        send_request(sample_item(1000, 1000));
        // zero limit clamps any error
        send_request(start_item(40000, 0));
        send_request(sample_item(0, COUNT_TOP));
        send_request(start_item(COUNT_TOP, 25600));
        send_request(sample_item(0, 0));
        send_request(sample_item(0, 0));
        run_moves(140);
        drain();

        program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
        hold_long   = 1;
        tx_max_wait = 0;
        run_moves(140);
        drain();

        tx_max_wait = 16;
        program_gains('0, '0, '0);
        run_moves(140);
        drain();

        tx_max_wait = 0;
        rx_max_wait = 0;
        program_gains(GAIN_BITS'($urandom), GAIN_BITS'($urandom), GAIN_BITS'($urandom));
        run_moves(140);
        drain();

        tx_max_wait = 16;
        rx_max_wait = 16;
        program_gains(GAIN_MAX, '0, GAIN_BITS'($urandom));
        run_moves(140);
        drain();

        program_gains(GAIN_BITS'($urandom_range(0, 65535)), GAIN_BITS'($urandom_range(0, 4095)),
                      GAIN_BITS'($urandom_range(0, 65535)));
        run_moves(140);
        drain();

        // long move with one wheel far ahead and the other far behind
        tx_max_wait = 0;
        rx_max_wait = 0;
        program_gains(dwpd_pkg::PROP_GAIN_RESET, dwpd_pkg::INTEG_GAIN_RESET,
                      dwpd_pkg::DERIV_GAIN_RESET);
        send_request(start_item(32768, $urandom_range(0, LIMIT_TOP)));
        repeat (40) send_request(sample_item(COUNT_TOP, 0));
        send_request(sample_item(32768, 32768));
        drain();

        if (book.failures == 0 && book.expected_q.size() == 0)
            $display("dual_wheel_pid_drive verification clean");
        else
            $display("dual_wheel_pid_drive verification failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("dual_wheel_pid_drive verification failed");
        $finish;
    end

endmodule

### dual_wheel_pid_drive.f
rtl/dwpd_pkg.sv
rtl/dwpd_lane.sv
rtl/dual_wheel_pid_drive.sv
tb/sv/dual_wheel_pid_drive_test.sv
